// File: sv/stsr_pkg.sv
// ----------------------------------------------------------------------------
// stsr_pkg
// Shared types and constants for the segmented transfer receiver.
// ----------------------------------------------------------------------------
package stsr_pkg;

    // Request kinds carried in the input sideband
    localparam logic [1:0] REQ_START  = 2'd0;
    localparam logic [1:0] REQ_PACKET = 2'd1;
    localparam logic [1:0] REQ_TICK   = 2'd2;

    // Status codes reported with every result
    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_BUSY     = 3'd1;
    localparam logic [2:0] ST_OK       = 3'd2;
    localparam logic [2:0] ST_TIMEOUT  = 3'd3;
    localparam logic [2:0] ST_OVERFLOW = 3'd4;
    localparam logic [2:0] ST_INVALID  = 3'd5;

    // Control byte bit positions
    localparam int unsigned CTRL_ACK_REQ = 7;
    localparam int unsigned CTRL_IS_ACK  = 6;
    localparam int unsigned CTRL_EOT     = 5;

    // Largest payload of one packet in bytes
    localparam logic [7:0]  MAX_PAYLOAD    = 8'd189;
    localparam logic [15:0] MAX_PAYLOAD_16 = 16'(MAX_PAYLOAD);

    // Configuration register indexes
    localparam logic [1:0] CFG_NEXT_TIMEOUT = 2'd2;

    localparam logic [15:0] NEXT_TIMEOUT_RESET = 16'd1000;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'b001,
        PH_FIRST = 3'b010,
        PH_NEXT  = 3'b100
    } phase_t;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] start_timeout_ms;
        logic        wait_forever;
        logic [15:0] buffer_bytes;
        logic [15:0] src_address;
        logic [7:0]  src_channel;
        logic [7:0]  control_bits;
        logic [7:0]  transaction;
        logic [7:0]  packet_total;
        logic [7:0]  seq_index;
        logic [7:0]  payload_bytes;
    } item_t;

    typedef struct packed {
        logic        ack_send;
        logic [15:0] ack_dest_address;
        logic [7:0]  ack_dest_channel;
        logic [7:0]  ack_transaction;
        logic [7:0]  ack_total;
        logic [7:0]  ack_index;
        logic        store_payload;
        logic [15:0] store_offset;
        logic [2:0]  status;
        logic [15:0] received_total;
        logic [7:0]  progress_index;
        logic [7:0]  progress_total;
    } result_t;

    typedef struct packed {
        logic        we;
        logic [1:0]  index;
        logic [15:0] data;
    } cfg_t;

endpackage

// File: sv/stsr_core.sv
// ----------------------------------------------------------------------------
// stsr_core
// Reception state and per-transaction decision logic.
// ----------------------------------------------------------------------------
module stsr_core
(
    input  logic             clk,
    input  logic             rst_n,
    input  stsr_pkg::cfg_t   cfg,
    input  logic             step,
    input  stsr_pkg::item_t  item,
    output stsr_pkg::result_t res
);

    stsr_pkg::phase_t phase_reg, phase_next;
    logic [15:0] remaining_reg, remaining_next;
    logic        no_deadline_reg, no_deadline_next;
    logic [7:0]  expected_reg, expected_next;
    logic [7:0]  trans_reg, trans_next;
    logic [7:0]  announced_reg, announced_next;
    logic [15:0] written_reg, written_next;
    logic [15:0] capacity_reg, capacity_next;
    logic [15:0] next_timeout_reg;

    logic [7:0]  plen;
    logic [15:0] need_bytes;
    logic        is_ack;
    logic        fin;
    logic        last;

    assign plen       = (item.payload_bytes > stsr_pkg::MAX_PAYLOAD) ?
                        stsr_pkg::MAX_PAYLOAD : item.payload_bytes;
    assign need_bytes = 16'(item.packet_total) * stsr_pkg::MAX_PAYLOAD_16;
    assign is_ack     = item.control_bits[stsr_pkg::CTRL_IS_ACK];
    assign last       = ({1'b0, expected_reg} + 9'd1) == {1'b0, announced_reg};

    always_comb
    begin
        phase_next       = phase_reg;
        remaining_next   = remaining_reg;
        no_deadline_next = no_deadline_reg;
        expected_next    = expected_reg;
        trans_next       = trans_reg;
        announced_next   = announced_reg;
        written_next     = written_reg;
        capacity_next    = capacity_reg;
        fin              = 1'b0;
        res              = '0;
        res.status       = (phase_reg == stsr_pkg::PH_IDLE) ?
                           stsr_pkg::ST_IDLE : stsr_pkg::ST_BUSY;

        case (item.req_type)
            stsr_pkg::REQ_START:
            begin
                written_next     = '0;
                capacity_next    = item.buffer_bytes;
                expected_next    = '0;
                announced_next   = '0;
                trans_next       = '0;
                no_deadline_next = item.wait_forever;
                remaining_next   = item.start_timeout_ms;
                if (!item.wait_forever && item.start_timeout_ms == '0)
                begin
                    fin        = 1'b1;
                    res.status = stsr_pkg::ST_TIMEOUT;
                end
                else
                begin
                    phase_next = stsr_pkg::PH_FIRST;
                    res.status = stsr_pkg::ST_BUSY;
                end
            end
            stsr_pkg::REQ_PACKET:
            begin
                if (phase_reg == stsr_pkg::PH_FIRST && !is_ack && item.seq_index == '0)
                begin
                    if (need_bytes > capacity_reg)
                    begin
                        fin        = 1'b1;
                        res.status = stsr_pkg::ST_OVERFLOW;
                    end
                    else
                    begin
                        res.store_payload = 1'b1;
                        res.ack_send      = item.control_bits[stsr_pkg::CTRL_ACK_REQ];
                        written_next      = 16'(plen);
                        if (item.control_bits[stsr_pkg::CTRL_EOT] ||
                            item.packet_total <= 8'd1)
                        begin
                            fin        = 1'b1;
                            res.status = stsr_pkg::ST_OK;
                        end
                        else
                        begin
                            phase_next       = stsr_pkg::PH_NEXT;
                            announced_next   = item.packet_total;
                            trans_next       = item.transaction;
                            expected_next    = 8'd1;
                            no_deadline_next = 1'b0;
                            remaining_next   = next_timeout_reg;
                            res.status       = stsr_pkg::ST_BUSY;
                        end
                    end
                end
                else if (phase_reg == stsr_pkg::PH_NEXT && !is_ack &&
                         item.transaction == trans_reg && item.seq_index == expected_reg)
                begin
                    res.store_payload = 1'b1;
                    res.store_offset  = written_reg;
                    res.ack_send      = item.control_bits[stsr_pkg::CTRL_ACK_REQ];
                    written_next      = written_reg + 16'(plen);
                    if (last)
                    begin
                        fin        = 1'b1;
                        res.status = item.control_bits[stsr_pkg::CTRL_EOT] ?
                                     stsr_pkg::ST_OK : stsr_pkg::ST_INVALID;
                    end
                    else
                    begin
                        expected_next  = expected_reg + 8'd1;
                        remaining_next = next_timeout_reg;
                        res.status     = stsr_pkg::ST_BUSY;
                    end
                end
            end
            stsr_pkg::REQ_TICK:
            begin
                if (phase_reg != stsr_pkg::PH_IDLE && !no_deadline_reg)
                begin
                    if (remaining_reg <= 16'd1)
                    begin
                        fin        = 1'b1;
                        res.status = stsr_pkg::ST_TIMEOUT;
                    end
                    else
                    begin
                        remaining_next = remaining_reg - 16'd1;
                    end
                end
            end
            default:
            begin
            end
        endcase

        // any end of transfer drops back to idle; byte count is kept
        if (fin)
        begin
            phase_next       = stsr_pkg::PH_IDLE;
            expected_next    = '0;
            announced_next   = '0;
            no_deadline_next = 1'b0;
            remaining_next   = '0;
        end

        if (res.ack_send)
        begin
            res.ack_dest_address = item.src_address;
            res.ack_dest_channel = item.src_channel;
            res.ack_transaction  = item.transaction;
            res.ack_total        = item.packet_total;
            res.ack_index        = item.seq_index;
        end

        res.received_total = written_next;
        res.progress_index = expected_next;
        res.progress_total = announced_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= stsr_pkg::PH_IDLE;
            remaining_reg    <= '0;
            no_deadline_reg  <= 1'b0;
            expected_reg     <= '0;
            trans_reg        <= '0;
            announced_reg    <= '0;
            written_reg      <= '0;
            capacity_reg     <= '0;
            next_timeout_reg <= stsr_pkg::NEXT_TIMEOUT_RESET;
        end
        else
        begin
            if (step)
            begin
                phase_reg       <= phase_next;
                remaining_reg   <= remaining_next;
                no_deadline_reg <= no_deadline_next;
                expected_reg    <= expected_next;
                trans_reg       <= trans_next;
                announced_reg   <= announced_next;
                written_reg     <= written_next;
                capacity_reg    <= capacity_next;
            end
            if (cfg.we && cfg.index == stsr_pkg::CFG_NEXT_TIMEOUT)
            begin
                next_timeout_reg <= cfg.data;
            end
        end
    end

endmodule

// File: sv/segmented_transfer_receiver_unit.sv
// ----------------------------------------------------------------------------
// segmented_transfer_receiver_unit
// Receive side of a segmented stop-and-wait transfer.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_*): one transaction per request. s_tuser holds the request
//   kind (start, packet header, 1 ms tick); s_tdata holds the header fields.
//   Output stream (m_*): exactly one result transaction per input transaction,
//   in order: ACK header fields, payload store offset, status and progress.
//   Configuration: cfg_we/cfg_index/cfg_data write a register while cfg_we is high;
//   write only while the block is idle. Index 2 is the following-packet
//   timeout. Indexes 0 and 1 (own address and channel) only matter to the
//   ACK framer downstream and are not held here.
// Path: an accepted input transaction is held in the input register, then
//   the decision logic feeds the result register, which drives the output.
// Throughput: one transaction per cycle while the result side is not
//   stalled; the decision logic is combinational between the two registers.
//   The reception state updates at the edge that loads the result register.
// Reset: no reception in progress, byte count zero, timeout reload 1000 ms;
//   both pipeline registers empty.
// Stall: when m_tready is low, the result register holds and the input
//   register fills; s_tready drops only when both are occupied.
// ----------------------------------------------------------------------------
module segmented_transfer_receiver_unit
(
    input  logic         clk,
    input  logic         rst_n,

    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [15:0]  cfg_data,

    input  logic         s_tvalid,
    output logic         s_tready,
    // [1:0] req_type
    input  logic [1:0]   s_tuser,
    // [15:0] start_timeout_ms, [16] wait_forever, [32:17] buffer_bytes,
    // [48:33] src_address, [56:49] src_channel, [64:57] control_bits,
    // [72:65] transaction, [80:73] packet_total, [88:81] seq_index,
    // [96:89] payload_bytes, [103:97] zero
    input  logic [103:0] s_tdata,

    output logic         m_tvalid,
    input  logic         m_tready,
    // [0] ack_send, [16:1] ack_dest_address, [24:17] ack_dest_channel,
    // [32:25] ack_transaction, [40:33] ack_total, [48:41] ack_index,
    // [49] store_payload, [65:50] store_offset, [68:66] status,
    // [84:69] received_total, [92:85] progress_index, [100:93] progress_total,
    // [103:101] zero
    output logic [103:0] m_tdata
);

    stsr_pkg::item_t   in_item_reg;
    logic              in_valid_reg;
    stsr_pkg::result_t out_res_reg;
    logic              out_valid_reg;
    stsr_pkg::result_t core_res;
    stsr_pkg::cfg_t    cfg;
    logic              advance;

    // item moves from the input register into the result register
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign cfg.we    = cfg_we;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_item_reg.req_type         <= s_tuser;
            in_item_reg.start_timeout_ms <= s_tdata[15:0];
            in_item_reg.wait_forever     <= s_tdata[16];
            in_item_reg.buffer_bytes     <= s_tdata[32:17];
            in_item_reg.src_address      <= s_tdata[48:33];
            in_item_reg.src_channel      <= s_tdata[56:49];
            in_item_reg.control_bits     <= s_tdata[64:57];
            in_item_reg.transaction      <= s_tdata[72:65];
            in_item_reg.packet_total     <= s_tdata[80:73];
            in_item_reg.seq_index        <= s_tdata[88:81];
            in_item_reg.payload_bytes    <= s_tdata[96:89];
        end
    end

    stsr_core u_core
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .step  (advance),
        .item  (in_item_reg),
        .res   (core_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_res_reg <= core_res;
        end
    end

    assign m_tvalid         = out_valid_reg;
    assign m_tdata[0]       = out_res_reg.ack_send;
    assign m_tdata[16:1]    = out_res_reg.ack_dest_address;
    assign m_tdata[24:17]   = out_res_reg.ack_dest_channel;
    assign m_tdata[32:25]   = out_res_reg.ack_transaction;
    assign m_tdata[40:33]   = out_res_reg.ack_total;
    assign m_tdata[48:41]   = out_res_reg.ack_index;
    assign m_tdata[49]      = out_res_reg.store_payload;
    assign m_tdata[65:50]   = out_res_reg.store_offset;
    assign m_tdata[68:66]   = out_res_reg.status;
    assign m_tdata[84:69]   = out_res_reg.received_total;
    assign m_tdata[92:85]   = out_res_reg.progress_index;
    assign m_tdata[100:93]  = out_res_reg.progress_total;
    assign m_tdata[103:101] = 3'b000;

endmodule

// File: verif/tb_segmented_transfer_receiver_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_segmented_transfer_receiver_unit
// Self-checking bench for the segmented transfer receiver. Directed requests
// cover idle input, zero budgets, restarts, overflow, single-packet and
// invalid-last cases; then random transfers mixed with stray
// packets, ticks and noise run under several register settings. Every input
// transaction is predicted by the scoreboard and compared with its result.
// ----------------------------------------------------------------------------
module tb_segmented_transfer_receiver_unit;

    // Codes the package does not name
    localparam logic [1:0] REQ_UNKNOWN   = 2'd3;
    localparam logic [1:0] CFG_NODE_ADDR = 2'd0;
    localparam logic [1:0] CFG_NODE_CHAN = 2'd1;

    localparam int          WATCHDOG_LIMIT   = 4000;   // cycles with no handshake
    localparam int          ITEMS_PER_PHASE  = 254;    // least number of items sent in each random phase
    localparam int          NUM_PHASES       = 6;
    localparam int          DRAIN_CYCLES     = 4;      // extra wait after the last predicted result is out
    localparam logic [7:0]  READY_PATTERN    = 8'b1011_0010;

    // ------------------------------------------------------------------------
    // Scoreboard: tracks reception state and holds predicted results in order
    // ------------------------------------------------------------------------
    class reassembly_scoreboard;
        // register copies (address and channel are held but never reported)
        logic [15:0] node_addr    = '0;
        logic [7:0]  node_chan    = '0;
        logic [15:0] next_budget  = stsr_pkg::NEXT_TIMEOUT_RESET;

        // reception state
        stsr_pkg::phase_t rx_phase = stsr_pkg::PH_IDLE;
        logic [15:0] budget_left  = '0;
        logic        untimed      = 1'b0;
        logic [7:0]  want_index   = '0;
        logic [7:0]  rx_trans     = '0;
        logic [7:0]  rx_total     = '0;
        logic [15:0] byte_count   = '0;
        logic [15:0] buf_capacity = '0;

        stsr_pkg::result_t pending_results[$];
        int          mismatches   = 0;

        function void set_reg(logic [1:0] idx, logic [15:0] value);
            case (idx)
                CFG_NODE_ADDR:              node_addr   = value;
                CFG_NODE_CHAN:              node_chan   = value[7:0];
                stsr_pkg::CFG_NEXT_TIMEOUT: next_budget = value;
                default: ;
            endcase
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        // any ending drops back to idle; the byte count survives until restart
        function void end_transfer();
            rx_phase    = stsr_pkg::PH_IDLE;
            want_index  = '0;
            rx_total    = '0;
            untimed     = 1'b0;
            budget_left = '0;
        endfunction

        // next-state and result of one request
        function stsr_pkg::result_t receive_step(stsr_pkg::item_t it);
            stsr_pkg::result_t r;
            logic [7:0]  plen;
            logic [2:0]  st;
            logic        ack;
            logic        store;
            logic [15:0] offset;
            logic        is_last;

            r      = '0;
            ack    = 1'b0;
            store  = 1'b0;
            offset = '0;
            plen   = (it.payload_bytes > stsr_pkg::MAX_PAYLOAD) ? stsr_pkg::MAX_PAYLOAD
                                                                : it.payload_bytes;
            st     = (rx_phase == stsr_pkg::PH_IDLE) ? stsr_pkg::ST_IDLE : stsr_pkg::ST_BUSY;

            case (it.req_type)
                stsr_pkg::REQ_START:
                begin
                    byte_count   = '0;
                    buf_capacity = it.buffer_bytes;
                    want_index   = '0;
                    rx_total     = '0;
                    rx_trans     = '0;
                    untimed      = it.wait_forever;
                    budget_left  = it.start_timeout_ms;
                    if (!it.wait_forever && it.start_timeout_ms == 16'd0)
                    begin
                        end_transfer();
                        st = stsr_pkg::ST_TIMEOUT;
                    end
                    else
                    begin
                        rx_phase = stsr_pkg::PH_FIRST;
                        st       = stsr_pkg::ST_BUSY;
                    end
                end
                stsr_pkg::REQ_PACKET:
                begin
                    if (rx_phase == stsr_pkg::PH_FIRST
                        && !it.control_bits[stsr_pkg::CTRL_IS_ACK]
                        && it.seq_index == 8'd0)
                    begin
                        if (int'(it.packet_total) * int'(stsr_pkg::MAX_PAYLOAD)
                            > int'(buf_capacity))
                        begin
                            end_transfer();
                            st = stsr_pkg::ST_OVERFLOW;
                        end
                        else
                        begin
                            store      = 1'b1;
                            byte_count = 16'(plen);
                            ack        = it.control_bits[stsr_pkg::CTRL_ACK_REQ];
                            if (it.control_bits[stsr_pkg::CTRL_EOT] || it.packet_total <= 8'd1)
                            begin
                                end_transfer();
                                st = stsr_pkg::ST_OK;
                            end
                            else
                            begin
                                rx_phase    = stsr_pkg::PH_NEXT;
                                rx_total    = it.packet_total;
                                rx_trans    = it.transaction;
                                want_index  = 8'd1;
                                untimed     = 1'b0;
                                budget_left = next_budget;
                                st          = stsr_pkg::ST_BUSY;
                            end
                        end
                    end
                    else if (rx_phase == stsr_pkg::PH_NEXT
                             && !it.control_bits[stsr_pkg::CTRL_IS_ACK]
                             && it.transaction == rx_trans && it.seq_index == want_index)
                    begin
                        // the total from the first packet bounds the transfer
                        is_last    = ({1'b0, want_index} + 9'd1) == {1'b0, rx_total};
                        store      = 1'b1;
                        offset     = byte_count;
                        byte_count = byte_count + 16'(plen);
                        ack        = it.control_bits[stsr_pkg::CTRL_ACK_REQ];
                        if (is_last)
                        begin
                            end_transfer();
                            st = it.control_bits[stsr_pkg::CTRL_EOT] ? stsr_pkg::ST_OK
                                                                     : stsr_pkg::ST_INVALID;
                        end
                        else
                        begin
                            want_index  = want_index + 8'd1;
                            budget_left = next_budget;
                            st          = stsr_pkg::ST_BUSY;
                        end
                    end
                end
                stsr_pkg::REQ_TICK:
                begin
                    if (rx_phase != stsr_pkg::PH_IDLE && !untimed)
                    begin
                        if (budget_left <= 16'd1)
                        begin
                            end_transfer();
                            st = stsr_pkg::ST_TIMEOUT;
                        end
                        else
                            budget_left = budget_left - 16'd1;
                    end
                end
                default: ;  // unknown request: no change
            endcase

            if (ack)
            begin
                r.ack_send         = 1'b1;
                r.ack_dest_address = it.src_address;
                r.ack_dest_channel = it.src_channel;
                r.ack_transaction  = it.transaction;
                r.ack_total        = it.packet_total;
                r.ack_index        = it.seq_index;
            end
            r.store_payload  = store;
            r.store_offset   = offset;
            r.status         = st;
            r.received_total = byte_count;
            r.progress_index = want_index;
            r.progress_total = rx_total;
            return r;
        endfunction

        function void note_transaction(stsr_pkg::item_t it);
            pending_results.push_back(receive_step(it));
        endfunction

        task report(string msg);
            $display("[%0t] MISMATCH: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_field(string name, logic [15:0] got, logic [15:0] want);
            if (got !== want)
                report($sformatf("%s got %h expected %h", name, got, want));
        endtask

        task check_result(stsr_pkg::result_t got);
            stsr_pkg::result_t want;
            if (pending_results.size() == 0)
            begin
                report("result with no transaction outstanding");
                return;
            end
            want = pending_results.pop_front();
            check_field("ack_send",         16'(got.ack_send),         16'(want.ack_send));
            check_field("ack_dest_address", got.ack_dest_address,      want.ack_dest_address);
            check_field("ack_dest_channel", 16'(got.ack_dest_channel), 16'(want.ack_dest_channel));
            check_field("ack_transaction",  16'(got.ack_transaction),  16'(want.ack_transaction));
            check_field("ack_total",        16'(got.ack_total),        16'(want.ack_total));
            check_field("ack_index",        16'(got.ack_index),        16'(want.ack_index));
            check_field("store_payload",    16'(got.store_payload),    16'(want.store_payload));
            check_field("store_offset",     got.store_offset,          want.store_offset);
            check_field("status",           16'(got.status),           16'(want.status));
            check_field("received_total",   got.received_total,        want.received_total);
            check_field("progress_index",   16'(got.progress_index),   16'(want.progress_index));
            check_field("progress_total",   16'(got.progress_total),   16'(want.progress_total));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Signals
    // ------------------------------------------------------------------------
    logic          clk       = 1'b0;
    logic          rst_n     = 1'b0;
    logic          cfg_we    = 1'b0;
    logic [1:0]    cfg_index = '0;
    logic [15:0]   cfg_data  = '0;
    logic          s_tvalid  = 1'b0;
    logic          s_tready;
    // [1:0] req_type
    logic [1:0]    s_tuser   = '0;
    // [15:0] start_timeout_ms, [16] wait_forever, [32:17] buffer_bytes,
    // [48:33] src_address, [56:49] src_channel, [64:57] control_bits,
    // [72:65] transaction, [80:73] packet_total, [88:81] seq_index,
    // [96:89] payload_bytes, [103:97] zero
    logic [103:0]  s_tdata   = '0;
    logic          m_tvalid;
    logic          m_tready  = 1'b0;
    // [0] ack_send, [16:1] ack_dest_address, [24:17] ack_dest_channel,
    // [32:25] ack_transaction, [40:33] ack_total, [48:41] ack_index,
    // [49] store_payload, [65:50] store_offset, [68:66] status,
    // [84:69] received_total, [92:85] progress_index, [100:93] progress_total
    logic [103:0]  m_tdata;

    stsr_pkg::item_t drv_item = '0;     // mirrors what s_tdata/s_tuser carry
    int            idle_cycles = 0;
    int            burst_left  = 0;
    int            sent_items  = 0;
    int            ready_mode  = 0;
    int            ready_hold  = 0;

    reassembly_scoreboard sb = new;

    segmented_transfer_receiver_unit u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Monitor and watchdog: both sides are sampled at the rising edge, before
    // any nonblocking update of that edge lands.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        stsr_pkg::result_t got;
        if (s_tvalid && s_tready)
            sb.note_transaction(drv_item);
        if (m_tvalid && m_tready)
        begin
            got.ack_send         = m_tdata[0];
            got.ack_dest_address = m_tdata[16:1];
            got.ack_dest_channel = m_tdata[24:17];
            got.ack_transaction  = m_tdata[32:25];
            got.ack_total        = m_tdata[40:33];
            got.ack_index        = m_tdata[48:41];
            got.store_payload    = m_tdata[49];
            got.store_offset     = m_tdata[65:50];
            got.status           = m_tdata[68:66];
            got.received_total   = m_tdata[84:69];
            got.progress_index   = m_tdata[92:85];
            got.progress_total   = m_tdata[100:93];
            sb.check_result(got);
        end

        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;

        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Result side back-pressure: each mode is held for a random stretch, so some
    // stretches never stall while others stall most of the time.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (ready_hold == 0)
        begin
            ready_mode <= $urandom_range(0, 3);
            ready_hold <= $urandom_range(32, 200);
        end
        else
            ready_hold <= ready_hold - 1;

        case (ready_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            2:       m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= READY_PATTERN[ready_hold % 8];
        endcase
    end

    // ------------------------------------------------------------------------
    // Request builders
    // ------------------------------------------------------------------------
    function automatic stsr_pkg::item_t rand_item();
        stsr_pkg::item_t it;
        it.req_type         = 2'($urandom);
        it.start_timeout_ms = 16'($urandom);
        it.wait_forever     = 1'($urandom);
        it.buffer_bytes     = 16'($urandom);
        it.src_address      = 16'($urandom);
        it.src_channel      = 8'($urandom);
        it.control_bits     = 8'($urandom);
        it.transaction      = 8'($urandom);
        it.packet_total     = 8'($urandom);
        it.seq_index        = 8'($urandom);
        it.payload_bytes    = 8'($urandom);
        return it;
    endfunction

    function automatic stsr_pkg::item_t simple_req(logic [1:0] kind);
        stsr_pkg::item_t it;
        it          = rand_item();
        it.req_type = kind;
        return it;
    endfunction

    function automatic stsr_pkg::item_t start_req(logic [15:0] budget, logic forever_wait,
                                                  logic [15:0] capacity_bytes);
        stsr_pkg::item_t it;
        it                  = simple_req(stsr_pkg::REQ_START);
        it.start_timeout_ms = budget;
        it.wait_forever     = forever_wait;
        it.buffer_bytes     = capacity_bytes;
        return it;
    endfunction

    function automatic stsr_pkg::item_t packet_req(logic [7:0] ctrl, logic [7:0] trans,
                                                   logic [7:0] total, logic [7:0] idx,
                                                   logic [7:0] plen);
        stsr_pkg::item_t it;
        it               = simple_req(stsr_pkg::REQ_PACKET);
        it.control_bits  = ctrl;
        it.transaction   = trans;
        it.packet_total  = total;
        it.seq_index     = idx;
        it.payload_bytes = plen;
        return it;
    endfunction

    // Something the receiver should skip while waiting for packet idx
    function automatic stsr_pkg::item_t stray_req(logic [7:0] trans, logic [7:0] idx);
        stsr_pkg::item_t it;
        it = rand_item();
        case ($urandom_range(0, 4))
            0, 1: it.req_type = stsr_pkg::REQ_TICK;
            2:
            begin
                it.req_type                           = stsr_pkg::REQ_PACKET;
                it.transaction                        = trans;
                it.seq_index                          = idx;
                it.control_bits[stsr_pkg::CTRL_IS_ACK] = 1'b1;
            end
            3:
            begin
                // out-of-order index, never equal to the expected one
                it.req_type    = stsr_pkg::REQ_PACKET;
                it.transaction = trans;
                it.seq_index   = idx + 8'($urandom_range(1, 4));
            end
            default:
            begin
                it.req_type  = stsr_pkg::REQ_PACKET;
                it.seq_index = idx;
                // the first packet takes any transaction, so flag it as an ACK
                if (idx == 8'd0)
                    it.control_bits[stsr_pkg::CTRL_IS_ACK] = 1'b1;
                else
                begin
                    it.transaction                         = trans ^ 8'($urandom_range(1, 255));
                    it.control_bits[stsr_pkg::CTRL_IS_ACK] = 1'b0;
                end
            end
        endcase
        return it;
    endfunction

    // ------------------------------------------------------------------------
    // Driver: one transaction per call, in bursts with random gaps between
    // ------------------------------------------------------------------------
    task automatic send(stsr_pkg::item_t it);
        int gap;
        drv_item <= it;
        s_tuser  <= it.req_type;
        s_tdata  <= {7'd0, it.payload_bytes, it.seq_index, it.packet_total,
                     it.transaction, it.control_bits, it.src_channel,
                     it.src_address, it.buffer_bytes, it.wait_forever,
                     it.start_timeout_ms};
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        sent_items++;

        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 12);
            gap = $urandom_range(0, 10);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Wait until every predicted result is out, then let the bench settle
    task automatic drain();
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Registers change only after every pending result is out
    task automatic write_regs(logic [15:0] addr, logic [7:0] chan, logic [15:0] budget);
        s_tvalid <= 1'b0;
        burst_left = 0;
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_NODE_ADDR;
        cfg_data  <= addr;
        sb.set_reg(CFG_NODE_ADDR, addr);
        @(posedge clk);
        cfg_index <= CFG_NODE_CHAN;
        cfg_data  <= {8'd0, chan};
        sb.set_reg(CFG_NODE_CHAN, {8'd0, chan});
        @(posedge clk);
        cfg_index <= stsr_pkg::CFG_NEXT_TIMEOUT;
        cfg_data  <= budget;
        sb.set_reg(stsr_pkg::CFG_NEXT_TIMEOUT, budget);
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // One transfer: start, then packets in order with stray requests between.
    // Some are cut short or sized past the buffer on purpose.
    // ------------------------------------------------------------------------
    task automatic run_transfer();
        stsr_pkg::item_t it;
        int          total;
        int          n_pkts;
        int          need;
        int          capacity_bytes;
        logic [7:0]  trans;

        total = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
        trans = 8'($urandom);
        need  = total * int'(stsr_pkg::MAX_PAYLOAD);
        if ($urandom_range(0, 7) == 0 && need > 0)
            capacity_bytes = need - $urandom_range(1, 189);   // up to one packet short
        else
            capacity_bytes = need + $urandom_range(0, 400);
        if (capacity_bytes > 65535)
            capacity_bytes = 65535;

        it = start_req(($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                    : 16'($urandom_range(0, 6)),
                       ($urandom_range(0, 7) == 0), 16'(capacity_bytes));
        send(it);

        n_pkts = (total < 1) ? 1 : total;
        for (int idx = 0; idx < n_pkts; idx++)
        begin
            while ($urandom_range(0, 4) == 0)
                send(stray_req(trans, 8'(idx)));
            if ($urandom_range(0, 39) == 0)
                return;     // sender gives up mid-transfer

            it = packet_req(8'($urandom), trans,
                            (idx == 0) ? 8'(total) : 8'($urandom), 8'(idx),
                            ($urandom_range(0, 7) == 0) ? 8'($urandom)
                                                         : 8'($urandom_range(0, 189)));
            it.control_bits[stsr_pkg::CTRL_IS_ACK] = 1'b0;
            if (idx == n_pkts - 1)
                it.control_bits[stsr_pkg::CTRL_EOT] = ($urandom_range(0, 5) != 0);
            send(it);
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        stsr_pkg::item_t it;
        int    phase_start;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed, with registers at their reset values ---
        send(simple_req(stsr_pkg::REQ_TICK));                       // idle tick
        send(packet_req(8'h80, 8'h11, 8'd2, 8'd0, 8'd10));          // idle packet
        send(simple_req(REQ_UNKNOWN));
        send(start_req(16'd0, 1'b0, 16'hFFFF));                     // zero budget
        send(start_req(16'd0, 1'b1, 16'hFFFF));                     // wait forever
        send(simple_req(stsr_pkg::REQ_TICK));                       // no deadline
        send(packet_req(8'h40, 8'hA5, 8'd3, 8'd0, 8'd5));           // ACK frame, skipped
        send(packet_req(8'h80, 8'hA5, 8'd3, 8'd1, 8'd5));           // not index 0
        it = packet_req(8'h80, 8'hA5, 8'd3, 8'd0, 8'hFF);           // oversized payload
        it.src_address = 16'hFFFF;
        it.src_channel = 8'hFF;
        send(it);
        send(packet_req(8'h80, 8'h5A, 8'd3, 8'd1, 8'd7));           // other transaction
        send(packet_req(8'hA0, 8'hA5, 8'd9, 8'd1, 8'd0));           // early end mark
        it = packet_req(8'h9F, 8'hA5, 8'd3, 8'd2, 8'd189);          // last, no end mark
        it.src_address = 16'h0000;
        it.src_channel = 8'h00;
        send(it);
        send(start_req(16'd2, 1'b0, 16'd188));
        send(packet_req(8'h00, 8'h01, 8'd1, 8'd0, 8'd1));           // buffer overflow
        send(start_req(16'd2, 1'b0, 16'd0));
        send(packet_req(8'h00, 8'h01, 8'd0, 8'd0, 8'd0));           // total 0 fits
        send(start_req(16'd2, 1'b0, 16'd100));
        send(simple_req(stsr_pkg::REQ_TICK));
        send(simple_req(stsr_pkg::REQ_TICK));                       // budget runs out
        send(start_req(16'hFFFF, 1'b0, 16'hFFFF));
        send(packet_req(8'hA0, 8'hFF, 8'hFF, 8'd0, 8'd189));        // end mark on first
        send(start_req(16'd5, 1'b0, 16'd1000));
        send(packet_req(8'h00, 8'h33, 8'd2, 8'd0, 8'd50));
        send(start_req(16'd5, 1'b0, 16'd1000));                     // restart mid-transfer
        send(packet_req(8'h00, 8'h33, 8'd2, 8'd1, 8'd50));          // stale, skipped
        send(packet_req(8'h00, 8'h44, 8'd1, 8'd0, 8'd20));          // single packet

        // --- random phases, each under its own register setting ---
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0:       write_regs(16'hFFFF, 8'hFF, 16'd0);        // zero reload
                1:       write_regs(16'h0000, 8'h00, 16'd1);
                2:       write_regs(16'($urandom), 8'($urandom), 16'd3);
                3:       write_regs(16'hFFFF, 8'h00, 16'hFFFF);
                4:       write_regs(16'($urandom), 8'hFF, 16'($urandom_range(4, 12)));
                default: write_regs(16'h0000, 8'($urandom), stsr_pkg::NEXT_TIMEOUT_RESET);
            endcase
            phase_start = sent_items;
            while (sent_items - phase_start < ITEMS_PER_PHASE)
            begin
                if ($urandom_range(0, 9) == 0)
                    send(rand_item());      // noise of any kind
                else
                    run_transfer();
            end
        end

        s_tvalid <= 1'b0;
        drain();
        repeat (8) @(posedge clk);

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
